>>> hw/rtl/uvsa_pkg.sv
package uvsa_pkg;

	// Default sizing
	localparam int ENTRIES_DEF   = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Field widths
	localparam int VAL_W   = 24;
	localparam int OP_W    = 3;
	localparam int SLOT_W  = 5;
	localparam int MODE_W  = 2;
	localparam int TIME_W  = 16;
	localparam int COUNT_W = 6;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_SPEED  = 3'd1;
	localparam logic [OP_W-1:0] OP_OFFSET = 3'd2;
	localparam logic [OP_W-1:0] OP_ACTIVE = 3'd3;
	localparam logic [OP_W-1:0] OP_MODE   = 3'd4;
	localparam logic [OP_W-1:0] OP_READ   = 3'd5;

	// Axis modes
	localparam logic [MODE_W-1:0] MODE_WRAP   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLAMP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FROZEN = 2'd3;

	// Register indexes
	localparam logic CFG_PAUSED = 1'b0;
	localparam logic CFG_COUNT  = 1'b1;

	// One table entry as stored in the RAM; mode holds V in [3:2], U in [1:0]
	typedef struct packed {
		logic signed [VAL_W-1:0] u_off;
		logic signed [VAL_W-1:0] v_off;
		logic signed [VAL_W-1:0] u_spd;
		logic signed [VAL_W-1:0] v_spd;
		logic [2*MODE_W-1:0]     mode;
		logic                    active;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OP,
		ST_TICK,
		ST_DRAIN
	} state_t;

endpackage

>>> hw/rtl/uvsa_ram.sv
module uvsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/uvsa_axis.sv
module uvsa_axis #(
	parameter int FRAC_BITS = uvsa_pkg::FRAC_BITS_DEF
) (
	input  logic [uvsa_pkg::MODE_W-1:0]       mode,
	input  logic signed [uvsa_pkg::VAL_W-1:0] offset,
	input  logic signed [uvsa_pkg::VAL_W-1:0] speed,
	input  logic signed [uvsa_pkg::VAL_W+uvsa_pkg::TIME_W:0] prod,
	output logic signed [uvsa_pkg::VAL_W-1:0] new_offset,
	output logic signed [uvsa_pkg::VAL_W-1:0] new_speed,
	output logic                              stop
);

	localparam int W  = uvsa_pkg::VAL_W;
	localparam int PW = uvsa_pkg::VAL_W + uvsa_pkg::TIME_W + 1;
	localparam logic signed [W-1:0] ONE_V       = W'(1 << FRAC_BITS);
	localparam logic signed [W-1:0] NEAR_ONE_V  = W'(((1 << FRAC_BITS) * 999 + 500) / 1000);
	localparam logic signed [W-1:0] NEAR_ZERO_V = W'(((1 << FRAC_BITS) + 500) / 1000);
	localparam logic signed [W-1:0] MAX_V       = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MIN_V       = {1'b1, {(W-1){1'b0}}};

	logic signed [PW-uvsa_pkg::TIME_W-1:0] step;
	logic signed [W+1:0]                   sum;
	logic signed [W-1:0]                   o;
	logic signed [W-1:0]                   neg_s;
	logic                                  s_pos;
	logic                                  s_neg;
	logic                                  o_ge_one;
	logic                                  o_le_zero;

	// floor(speed * time / 2^16): arithmetic drop of the low time bits
	assign step = prod[PW-1:uvsa_pkg::TIME_W];
	assign sum  = {{2{offset[W-1]}}, offset} + {step[PW-uvsa_pkg::TIME_W-1], step};

	// Saturate to the signed 24-bit range
	always_comb begin
		if (!sum[W+1] && (sum[W:W-1] != 2'b00)) begin
			o = MAX_V;
		end else if (sum[W+1] && (sum[W:W-1] != 2'b11)) begin
			o = MIN_V;
		end else begin
			o = sum[W-1:0];
		end
	end

	assign s_pos     = !speed[W-1] && (speed != '0);
	assign s_neg     = speed[W-1];
	assign o_ge_one  = (o >= ONE_V);
	assign o_le_zero = o[W-1] || (o == '0);
	// Negating the most negative speed saturates
	assign neg_s     = (speed == MIN_V) ? MAX_V : -speed;

	// Edge handling per mode
	always_comb begin
		new_offset = o;
		new_speed  = speed;
		stop       = 1'b0;
		case (mode)
			uvsa_pkg::MODE_WRAP: begin
				if (s_pos && o_ge_one) begin
					new_offset = o - ONE_V;
				end
				if (s_neg && o_le_zero) begin
					new_offset = o + ONE_V;
				end
			end
			uvsa_pkg::MODE_MIRROR: begin
				if (o_ge_one) begin
					new_offset = NEAR_ONE_V;
					new_speed  = neg_s;
				end else if (o_le_zero) begin
					new_offset = NEAR_ZERO_V;
					new_speed  = neg_s;
				end
			end
			uvsa_pkg::MODE_CLAMP: begin
				if (s_pos && o_ge_one) begin
					new_offset = ONE_V;
					stop       = 1'b1;
				end
				if (s_neg && o_le_zero) begin
					new_offset = '0;
					stop       = 1'b1;
				end
			end
			default: begin
				// frozen axis keeps everything
				new_offset = offset;
			end
		endcase
	end

endmodule

>>> hw/rtl/uv_scroll_animator_top.sv
// Texture-scroll table: ENTRIES entries of U/V offset, U/V speed, axis modes
// and an active flag, held in one synchronous RAM word per entry.
// Command channel: an item is taken when start is high and busy is low.
// Each item gives one result, shown for one cycle with done high; the
// receiver cannot stall, so done and the result ports are never held.
// Set speeds, offsets, active, modes and read: read-modify-write of the
// addressed entry (read writes nothing back); done is registered from ST_OP.
// busy is high for one cycle, so no new item is taken until ST_OP ends.
// Tick: the entries below min(entry_count, ENTRIES) are walked one per cycle
// through a read, a multiply stage and an update stage; done is registered
// as the last entry is written back, busy high until then.
// The single RAM port pair sets the one-entry-per-cycle pace.
// A paused tick, a tick over zero entries, an unused op or a slot beyond the
// table answers zero in the cycle after acceptance, and busy stays low.
// Registers are written through wr_en/wr_index/wr_data; the user must do so
// only while no item is in flight, which the block itself does not enforce.
// After reset a clearing pass writes zero to every entry, one per cycle, with
// busy high; registers reset to zero.
module uv_scroll_animator_top #(
	parameter int ENTRIES   = uvsa_pkg::ENTRIES_DEF,
	parameter int FRAC_BITS = uvsa_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [uvsa_pkg::OP_W-1:0]             op,
	input  logic [uvsa_pkg::SLOT_W-1:0]           slot,
	input  logic signed [uvsa_pkg::VAL_W-1:0]     u_value,
	input  logic signed [uvsa_pkg::VAL_W-1:0]     v_value,
	input  logic [uvsa_pkg::MODE_W-1:0]           u_mode_in,
	input  logic [uvsa_pkg::MODE_W-1:0]           v_mode_in,
	input  logic                                  active_in,
	input  logic [uvsa_pkg::TIME_W-1:0]           frame_time,
	output logic                                  done,
	output logic signed [uvsa_pkg::VAL_W-1:0]     u_offset,
	output logic signed [uvsa_pkg::VAL_W-1:0]     v_offset,
	output logic signed [uvsa_pkg::VAL_W-1:0]     u_speed,
	output logic signed [uvsa_pkg::VAL_W-1:0]     v_speed,
	output logic                                  active_out,
	output logic [uvsa_pkg::MODE_W-1:0]           u_mode_out,
	output logic [uvsa_pkg::MODE_W-1:0]           v_mode_out,
	input  logic                                  wr_en,
	input  logic                                  wr_index,
	input  logic [uvsa_pkg::COUNT_W-1:0]          wr_data
);

	localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW  = (AW > uvsa_pkg::COUNT_W) ? AW : uvsa_pkg::COUNT_W;
	localparam int W   = uvsa_pkg::VAL_W;
	localparam int PW  = uvsa_pkg::VAL_W + uvsa_pkg::TIME_W + 1;
	localparam int EW  = $bits(uvsa_pkg::entry_t);
	// Count cap: ENTRIES, or the largest count the register can hold
	localparam logic [uvsa_pkg::COUNT_W-1:0] ENT_CAP =
		(ENTRIES < (1 << uvsa_pkg::COUNT_W)) ? uvsa_pkg::COUNT_W'(ENTRIES) :
		{uvsa_pkg::COUNT_W{1'b1}};
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
	localparam logic signed [W-1:0] ONE_V = W'(1 << FRAC_BITS);

	uvsa_pkg::state_t state_q, state_d;

	// Registers
	logic                           paused_q;
	logic [uvsa_pkg::COUNT_W-1:0]   entry_count_q;
	logic [uvsa_pkg::COUNT_W-1:0]   n_eff;

	// Latched item
	logic [uvsa_pkg::OP_W-1:0]      op_q;
	logic [AW-1:0]                  slot_q;
	logic signed [W-1:0]            u_value_q;
	logic signed [W-1:0]            v_value_q;
	logic [uvsa_pkg::MODE_W-1:0]    u_mode_q;
	logic [uvsa_pkg::MODE_W-1:0]    v_mode_q;
	logic                           active_q;
	logic [uvsa_pkg::TIME_W-1:0]    frame_time_q;

	// Counters
	logic [AW-1:0]                  clr_q;
	logic [AW-1:0]                  idx_q;

	// Tick pipeline
	logic                           v_s1;
	logic [AW-1:0]                  addr_s1;
	logic                           v_s2;
	logic [AW-1:0]                  addr_s2;
	uvsa_pkg::entry_t               ent_s2;
	logic signed [PW-1:0]           prod_u_s2;
	logic signed [PW-1:0]           prod_v_s2;

	// RAM
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	uvsa_pkg::entry_t               ram_wdata;
	logic [AW-1:0]                  ram_raddr;
	uvsa_pkg::entry_t               ram_rdata;
	logic [EW-1:0]                  ram_rbits;

	// Result
	logic                           done_q;
	uvsa_pkg::entry_t               res_q;

	logic                           accept;
	logic                           slot_ok;
	logic                           op_valid;
	logic                           tick_go;
	logic                           clr_last;
	logic                           tick_last;
	logic                           zero_result;
	uvsa_pkg::entry_t               op_word;
	uvsa_pkg::entry_t               tick_word;
	logic signed [W-1:0]            u_new_off, v_new_off, u_new_spd, v_new_spd;
	logic                           u_stop, v_stop;

	assign accept    = start && !busy;
	assign slot_ok   = (32'(slot) < ENTRIES);
	assign op_valid  = (op >= uvsa_pkg::OP_SPEED) && (op <= uvsa_pkg::OP_READ) && slot_ok;
	assign n_eff     = (entry_count_q > ENT_CAP) ? ENT_CAP : entry_count_q;
	assign tick_go   = (op == uvsa_pkg::OP_TICK) && !paused_q && (n_eff != '0);
	assign clr_last  = (clr_q == LAST_ADDR);
	assign tick_last = (CW'(idx_q) == CW'(n_eff - uvsa_pkg::COUNT_W'(1)));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			uvsa_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = uvsa_pkg::ST_IDLE;
				end
			end
			uvsa_pkg::ST_IDLE: begin
				if (start) begin
					if (tick_go) begin
						state_d = uvsa_pkg::ST_TICK;
					end else if (op_valid) begin
						state_d = uvsa_pkg::ST_OP;
					end
				end
			end
			uvsa_pkg::ST_OP: begin
				state_d = uvsa_pkg::ST_IDLE;
			end
			uvsa_pkg::ST_TICK: begin
				if (tick_last) begin
					state_d = uvsa_pkg::ST_DRAIN;
				end
			end
			uvsa_pkg::ST_DRAIN: begin
				if (!v_s1) begin
					state_d = uvsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = uvsa_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs: handshake, RAM port control, zero-result strobe
	always_comb begin
		busy        = 1'b1;
		ram_we      = 1'b0;
		ram_waddr   = addr_s2;
		ram_wdata   = tick_word;
		ram_raddr   = idx_q;
		zero_result = 1'b0;
		case (state_q)
			uvsa_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			uvsa_pkg::ST_IDLE: begin
				busy        = 1'b0;
				ram_raddr   = AW'(slot);
				zero_result = start && !tick_go && !op_valid;
			end
			uvsa_pkg::ST_OP: begin
				ram_we    = (op_q != uvsa_pkg::OP_READ);
				ram_waddr = slot_q;
				ram_wdata = op_word;
			end
			uvsa_pkg::ST_TICK: begin
				ram_we = v_s2 && ent_s2.active;
			end
			uvsa_pkg::ST_DRAIN: begin
				ram_we      = v_s2 && ent_s2.active;
				zero_result = !v_s1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uvsa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q      <= 1'b0;
			entry_count_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				uvsa_pkg::CFG_PAUSED: paused_q      <= wr_data[0];
				uvsa_pkg::CFG_COUNT:  entry_count_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Clearing sweep and tick walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			idx_q <= '0;
		end else begin
			if (state_q == uvsa_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == uvsa_pkg::ST_TICK) begin
				idx_q <= idx_q + AW'(1);
			end else begin
				idx_q <= '0;
			end
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= op;
			slot_q       <= AW'(slot);
			u_value_q    <= u_value;
			v_value_q    <= v_value;
			u_mode_q     <= u_mode_in;
			v_mode_q     <= v_mode_in;
			active_q     <= active_in;
			frame_time_q <= frame_time;
		end
	end

	uvsa_ram #(
		.WIDTH(EW),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rbits)
	);

	assign ram_rdata = uvsa_pkg::entry_t'(ram_rbits);

	// Single-entry modify
	always_comb begin
		op_word = ram_rdata;
		case (op_q)
			uvsa_pkg::OP_SPEED: begin
				op_word.u_spd = u_value_q;
				op_word.v_spd = v_value_q;
			end
			uvsa_pkg::OP_OFFSET: begin
				op_word.u_off = u_value_q[W-1] ? '0 :
					((u_value_q > ONE_V) ? ONE_V : u_value_q);
				op_word.v_off = v_value_q[W-1] ? '0 :
					((v_value_q > ONE_V) ? ONE_V : v_value_q);
			end
			uvsa_pkg::OP_ACTIVE: begin
				op_word.active = active_q;
			end
			uvsa_pkg::OP_MODE: begin
				op_word.mode = {v_mode_q, u_mode_q};
			end
			default: begin
				op_word = ram_rdata;
			end
		endcase
	end

	// Tick stage 1: read data back, form speed * time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == uvsa_pkg::ST_TICK);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= idx_q;
		addr_s2   <= addr_s1;
		ent_s2    <= ram_rdata;
		prod_u_s2 <= ram_rdata.u_spd * $signed({1'b0, frame_time_q});
		prod_v_s2 <= ram_rdata.v_spd * $signed({1'b0, frame_time_q});
	end

	// Tick stage 2: per-axis update and write back
	uvsa_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_axis_u (
		.mode      (ent_s2.mode[uvsa_pkg::MODE_W-1:0]),
		.offset    (ent_s2.u_off),
		.speed     (ent_s2.u_spd),
		.prod      (prod_u_s2),
		.new_offset(u_new_off),
		.new_speed (u_new_spd),
		.stop      (u_stop)
	);

	uvsa_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_axis_v (
		.mode      (ent_s2.mode[2*uvsa_pkg::MODE_W-1:uvsa_pkg::MODE_W]),
		.offset    (ent_s2.v_off),
		.speed     (ent_s2.v_spd),
		.prod      (prod_v_s2),
		.new_offset(v_new_off),
		.new_speed (v_new_spd),
		.stop      (v_stop)
	);

	always_comb begin
		tick_word        = ent_s2;
		tick_word.u_off  = u_new_off;
		tick_word.u_spd  = u_new_spd;
		tick_word.v_off  = v_new_off;
		tick_word.v_spd  = v_new_spd;
		tick_word.active = ent_s2.active && !u_stop && !v_stop;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= zero_result || (state_q == uvsa_pkg::ST_OP);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == uvsa_pkg::ST_OP) begin
			res_q <= op_word;
		end else if (zero_result) begin
			res_q <= '0;
		end
	end

	assign done       = done_q;
	assign u_offset   = res_q.u_off;
	assign v_offset   = res_q.v_off;
	assign u_speed    = res_q.u_spd;
	assign v_speed    = res_q.v_spd;
	assign active_out = res_q.active;
	assign u_mode_out = res_q.mode[uvsa_pkg::MODE_W-1:0];
	assign v_mode_out = res_q.mode[2*uvsa_pkg::MODE_W-1:uvsa_pkg::MODE_W];

endmodule

>>> verif/uv_scroll_animator_check.sv
`timescale 1ns / 100ps

module uv_scroll_animator_check
	import uvsa_pkg::*;
#(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [OP_W-1:0]          op,
	input  logic [SLOT_W-1:0]        slot,
	input  logic signed [VAL_W-1:0]  u_value,
	input  logic signed [VAL_W-1:0]  v_value,
	input  logic [MODE_W-1:0]        u_mode_in,
	input  logic [MODE_W-1:0]        v_mode_in,
	input  logic                     active_in,
	input  logic [TIME_W-1:0]        frame_time,
	input  logic                     done,
	input  logic signed [VAL_W-1:0]  u_offset,
	input  logic signed [VAL_W-1:0]  v_offset,
	input  logic signed [VAL_W-1:0]  u_speed,
	input  logic signed [VAL_W-1:0]  v_speed,
	input  logic                     active_out,
	input  logic [MODE_W-1:0]        u_mode_out,
	input  logic [MODE_W-1:0]        v_mode_out,
	input  logic                     wr_en,
	input  logic                     wr_index,
	input  logic [COUNT_W-1:0]       wr_data,
	output int                       mismatch_count,
	output int                       outstanding
);

	// Fixed-point constants
	localparam longint ONE_FX       = 64'sd1 <<< FRAC_BITS;
	localparam longint NEAR_ONE_FX  = (ONE_FX * 999 + 500) / 1000;
	localparam longint NEAR_ZERO_FX = (ONE_FX + 500) / 1000;
	localparam longint VAL_MAX      = (64'sd1 <<< (VAL_W - 1)) - 1;
	localparam longint VAL_MIN      = -(64'sd1 <<< (VAL_W - 1));

	// Entry view returned for each item
	typedef struct packed {
		logic [VAL_W-1:0]  uo;
		logic [VAL_W-1:0]  vo;
		logic [VAL_W-1:0]  us;
		logic [VAL_W-1:0]  vs;
		logic              act;
		logic [MODE_W-1:0] um;
		logic [MODE_W-1:0] vm;
	} scroll_view_t;

	// One axis after a tick
	typedef struct packed {
		logic [VAL_W-1:0] off;
		logic [VAL_W-1:0] spd;
		logic             stop;
	} axis_t;

	// Shadow table and registers
	logic signed [VAL_W-1:0]  uo_tab [ENTRIES];
	logic signed [VAL_W-1:0]  vo_tab [ENTRIES];
	logic signed [VAL_W-1:0]  us_tab [ENTRIES];
	logic signed [VAL_W-1:0]  vs_tab [ENTRIES];
	logic [2*MODE_W-1:0]      mode_tab [ENTRIES];
	logic                     act_tab [ENTRIES];
	logic                     paused_r;
	logic [COUNT_W-1:0]       count_r;
	scroll_view_t             expected_views [$];

	function automatic logic signed [VAL_W-1:0] sat24(input longint v);
		if (v > VAL_MAX)
			return VAL_MAX[VAL_W-1:0];
		if (v < VAL_MIN)
			return VAL_MIN[VAL_W-1:0];
		return v[VAL_W-1:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] clamp_unit(input logic signed [VAL_W-1:0] v);
		if (v > ONE_FX)
			return ONE_FX[VAL_W-1:0];
		if (v < 0)
			return '0;
		return v;
	endfunction

	// Offset step with floor rounding, then the axis mode
	function automatic axis_t advance_axis(input logic [MODE_W-1:0] mode,
			input logic signed [VAL_W-1:0] off_in, spd_in, input logic [TIME_W-1:0] ft);
		axis_t  r;
		longint o;
		longint s;
		longint t_l;
		o = off_in;
		s = spd_in;
		t_l = ft;
		r.stop = 1'b0;
		r.off = off_in;
		r.spd = spd_in;
		if (mode != MODE_FROZEN) begin
			o = sat24(o + ((s * t_l) >>> TIME_W));
			case (mode)
				MODE_WRAP: begin
					if (s > 0 && o >= ONE_FX)
						o -= ONE_FX;
					if (s < 0 && o <= 0)
						o += ONE_FX;
				end
				MODE_MIRROR: begin
					if (o >= ONE_FX) begin
						o = NEAR_ONE_FX;
						s = -s;
					end else if (o <= 0) begin
						o = NEAR_ZERO_FX;
						s = -s;
					end
				end
				default: begin
					if (s > 0 && o >= ONE_FX) begin
						o = ONE_FX;
						r.stop = 1'b1;
					end
					if (s < 0 && o <= 0) begin
						o = 0;
						r.stop = 1'b1;
					end
				end
			endcase
			r.off = sat24(o);
			r.spd = sat24(s);
		end
		return r;
	endfunction

	// Apply one accepted item to the shadow table and queue its view
	task automatic apply_item();
		scroll_view_t view;
		axis_t        ax;
		int           n;
		view = '0;
		if (op == OP_TICK) begin
			n = (int'(count_r) > ENTRIES) ? ENTRIES : int'(count_r);
			if (!paused_r) begin
				for (int i = 0; i < n; i++) begin
					if (act_tab[i]) begin
						ax = advance_axis(mode_tab[i][MODE_W-1:0], uo_tab[i], us_tab[i],
							frame_time);
						uo_tab[i] = ax.off;
						us_tab[i] = ax.spd;
						if (ax.stop)
							act_tab[i] = 1'b0;
						// V still moves on the tick that a U clamp stops
						ax = advance_axis(mode_tab[i][2*MODE_W-1:MODE_W], vo_tab[i],
							vs_tab[i], frame_time);
						vo_tab[i] = ax.off;
						vs_tab[i] = ax.spd;
						if (ax.stop)
							act_tab[i] = 1'b0;
					end
				end
			end
		end else if (op <= OP_READ && int'(slot) < ENTRIES) begin
			case (op)
				OP_SPEED: begin
					us_tab[slot] = u_value;
					vs_tab[slot] = v_value;
				end
				OP_OFFSET: begin
					uo_tab[slot] = clamp_unit(u_value);
					vo_tab[slot] = clamp_unit(v_value);
				end
				OP_ACTIVE: act_tab[slot] = active_in;
				OP_MODE:   mode_tab[slot] = {v_mode_in, u_mode_in};
				default: ;
			endcase
			view.uo = uo_tab[slot];
			view.vo = vo_tab[slot];
			view.us = us_tab[slot];
			view.vs = vs_tab[slot];
			view.act = act_tab[slot];
			view.um = mode_tab[slot][MODE_W-1:0];
			view.vm = mode_tab[slot][2*MODE_W-1:MODE_W];
		end
		expected_views.push_back(view);
	endtask

	task automatic check_field(input string name, input logic [VAL_W-1:0] want, got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
				$signed(want), $signed(got));
			mismatch_count++;
		end
	endtask

	task automatic compare_result();
		scroll_view_t want;
		if (expected_views.size() == 0) begin
			$display("%0t ns: result with no item outstanding, actual u_offset %0d",
				$time, u_offset);
			mismatch_count++;
		end else begin
			want = expected_views.pop_front();
			check_field("u_offset", want.uo, u_offset);
			check_field("v_offset", want.vo, v_offset);
			check_field("u_speed", want.us, u_speed);
			check_field("v_speed", want.vs, v_speed);
			check_field("active_out", {{(VAL_W-1){1'b0}}, want.act}, {{(VAL_W-1){1'b0}},
				active_out});
			check_field("u_mode_out", {{(VAL_W-MODE_W){1'b0}}, want.um},
				{{(VAL_W-MODE_W){1'b0}}, u_mode_out});
			check_field("v_mode_out", {{(VAL_W-MODE_W){1'b0}}, want.vm},
				{{(VAL_W-MODE_W){1'b0}}, v_mode_out});
		end
	endtask

	// Results first, then register writes, then the newly accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				uo_tab[i] = '0;
				vo_tab[i] = '0;
				us_tab[i] = '0;
				vs_tab[i] = '0;
				mode_tab[i] = '0;
				act_tab[i] = 1'b0;
			end
			paused_r = 1'b0;
			count_r = '0;
			expected_views.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (done)
				compare_result();
			if (wr_en) begin
				if (wr_index == CFG_PAUSED)
					paused_r = wr_data[0];
				else
					count_r = wr_data;
			end
			if (start && !busy)
				apply_item();
			outstanding = expected_views.size();
		end
	end

endmodule

>>> verif/uv_scroll_animator_top_test.sv
`timescale 1ns / 100ps

module uv_scroll_animator_top_test;
	import uvsa_pkg::*;

	localparam int LIMIT_CYCLES   = 400000;
	localparam int PHASE_ITEMS    = 85;
	localparam logic [COUNT_W-1:0] FULL_COUNT = ENTRIES_DEF[COUNT_W-1:0];
	localparam logic [VAL_W-1:0]   VAL_TOP    = 24'h7FFFFF;
	localparam logic [VAL_W-1:0]   VAL_BOTTOM = 24'h800000;
	localparam logic [VAL_W-1:0]   UNIT       = 24'h010000;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [OP_W-1:0]         op;
	logic [SLOT_W-1:0]       slot;
	logic signed [VAL_W-1:0] u_value;
	logic signed [VAL_W-1:0] v_value;
	logic [MODE_W-1:0]       u_mode_in;
	logic [MODE_W-1:0]       v_mode_in;
	logic                    active_in;
	logic [TIME_W-1:0]       frame_time;
	logic                    done;
	logic signed [VAL_W-1:0] u_offset;
	logic signed [VAL_W-1:0] v_offset;
	logic signed [VAL_W-1:0] u_speed;
	logic signed [VAL_W-1:0] v_speed;
	logic                    active_out;
	logic [MODE_W-1:0]       u_mode_out;
	logic [MODE_W-1:0]       v_mode_out;
	logic                    wr_en;
	logic                    wr_index;
	logic [COUNT_W-1:0]      wr_data;

	int mismatch_count;
	int outstanding;
	int idle_pct;
	int cycle_cnt;

	// Which parts of each entry have been written
	bit speed_written [ENTRIES_DEF];
	bit offset_written [ENTRIES_DEF];
	bit mode_written [ENTRIES_DEF];

	uv_scroll_animator_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .slot(slot),
		.u_value(u_value), .v_value(v_value), .u_mode_in(u_mode_in), .v_mode_in(v_mode_in),
		.active_in(active_in), .frame_time(frame_time), .done(done), .u_offset(u_offset),
		.v_offset(v_offset), .u_speed(u_speed), .v_speed(v_speed), .active_out(active_out),
		.u_mode_out(u_mode_out), .v_mode_out(v_mode_out), .wr_en(wr_en),
		.wr_index(wr_index), .wr_data(wr_data)
	);

	uv_scroll_animator_check checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .slot(slot),
		.u_value(u_value), .v_value(v_value), .u_mode_in(u_mode_in), .v_mode_in(v_mode_in),
		.active_in(active_in), .frame_time(frame_time), .done(done), .u_offset(u_offset),
		.v_offset(v_offset), .u_speed(u_speed), .v_speed(v_speed), .active_out(active_out),
		.u_mode_out(u_mode_out), .v_mode_out(v_mode_out), .wr_en(wr_en),
		.wr_index(wr_index), .wr_data(wr_data), .mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Run guard
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Mostly values near the unit range, some full-width and edge values
	function automatic logic [VAL_W-1:0] rand_val();
		logic [31:0] r;
		case ($urandom_range(4))
			0: r = $urandom();
			1: r = $urandom_range(65536);
			2: r = $urandom_range(262143) - 131072;
			3: begin
				case ($urandom_range(3))
					0: r = {8'h00, VAL_TOP};
					1: r = {8'h00, VAL_BOTTOM};
					2: r = '0;
					default: r = {8'h00, UNIT};
				endcase
			end
			default: r = $urandom_range(2048);
		endcase
		return r[VAL_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [31:0] r;
		case ($urandom_range(3))
			0: r = $urandom_range(65535);
			1: r = $urandom_range(8192);
			2: r = $urandom_range(1) ? 32'hFFFF : 32'h0;
			default: r = $urandom_range(2048);
		endcase
		return r[TIME_W-1:0];
	endfunction

	function automatic bit slot_ready(input logic [SLOT_W-1:0] s);
		return speed_written[s] && offset_written[s] && mode_written[s];
	endfunction

	// Present one item, with a random gap before it, and wait for acceptance
	task automatic send_item(input logic [OP_W-1:0] o, input logic [SLOT_W-1:0] s,
			input logic [VAL_W-1:0] uv, vv, input logic [MODE_W-1:0] um, vm,
			input logic a, input logic [TIME_W-1:0] ft);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		op <= o;
		slot <= s;
		u_value <= uv;
		v_value <= vv;
		u_mode_in <= um;
		v_mode_in <= vm;
		active_in <= a;
		frame_time <= ft;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		if (o == OP_SPEED)
			speed_written[s] = 1'b1;
		if (o == OP_OFFSET)
			offset_written[s] = 1'b1;
		if (o == OP_MODE)
			mode_written[s] = 1'b1;
	endtask

	// Hold off until every result is back and the block is idle
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Weighted op mix; reads and activation only on fully written slots
	task automatic random_item();
		logic [OP_W-1:0]   o;
		logic [SLOT_W-1:0] s;
		int                pick;
		s = SLOT_W'($urandom_range(ENTRIES_DEF - 1));
		pick = $urandom_range(99);
		if (pick < 25)
			o = OP_TICK;
		else if (pick < 40)
			o = OP_SPEED;
		else if (pick < 55)
			o = OP_OFFSET;
		else if (pick < 65)
			o = OP_MODE;
		else if (pick < 80)
			o = OP_ACTIVE;
		else if (pick < 96)
			o = OP_READ;
		else
			o = OP_W'($urandom_range(6, 7));
		if ((o == OP_ACTIVE || o == OP_READ) && !slot_ready(s))
			o = !speed_written[s] ? OP_SPEED : !offset_written[s] ? OP_OFFSET : OP_MODE;
		send_item(o, s, rand_val(), rand_val(), MODE_W'($urandom_range(3)),
			MODE_W'($urandom_range(3)), $urandom_range(99) < 75, rand_time());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_TICK;
		slot = '0;
		u_value = '0;
		v_value = '0;
		u_mode_in = MODE_WRAP;
		v_mode_in = MODE_WRAP;
		active_in = 1'b0;
		frame_time = '0;
		wr_en = 1'b0;
		wr_index = CFG_PAUSED;
		wr_data = '0;
		idle_pct = 23;
		for (int i = 0; i < ENTRIES_DEF; i++) begin
			speed_written[i] = 1'b0;
			offset_written[i] = 1'b0;
			mode_written[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// clearing pass keeps busy high
		wait_drained();
		write_reg(CFG_PAUSED, '0);
		write_reg(CFG_COUNT, FULL_COUNT);

		// Slot 0: extreme speeds, offsets clamped to 0 and one, clamp on U
		send_item(OP_SPEED, 5'd0, VAL_TOP, VAL_BOTTOM, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_OFFSET, 5'd0, VAL_BOTTOM, VAL_TOP, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_MODE, 5'd0, '0, '0, MODE_CLAMP, MODE_MIRROR, 1'b0, '0);
		send_item(OP_ACTIVE, 5'd0, '0, '0, MODE_WRAP, MODE_WRAP, 1'b1, '0);
		// Last slot: wrap on U, frozen V
		send_item(OP_SPEED, 5'd31, 24'h001000, 24'hFFE000, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_OFFSET, 5'd31, 24'h008000, 24'h000100, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_MODE, 5'd31, '0, '0, MODE_WRAP, MODE_FROZEN, 1'b0, '0);
		send_item(OP_ACTIVE, 5'd31, '0, '0, MODE_WRAP, MODE_WRAP, 1'b1, '0);
		// Slot 7: mirror on U, wrap on V
		send_item(OP_MODE, 5'd7, '0, '0, MODE_MIRROR, MODE_WRAP, 1'b0, '0);
		send_item(OP_SPEED, 5'd7, 24'hFF0000, 24'h020000, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_OFFSET, 5'd7, 24'h000800, 24'h00F000, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_ACTIVE, 5'd7, '0, '0, MODE_WRAP, MODE_WRAP, 1'b1, '0);
		// Longest frame, then zero and short frames
		send_item(OP_TICK, 5'd0, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, 16'hFFFF);
		send_item(OP_READ, 5'd0, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_READ, 5'd31, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_READ, 5'd7, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_TICK, 5'd0, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_TICK, 5'd0, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, 16'h0800);
		// Unused ops
		send_item(3'd6, 5'd5, rand_val(), rand_val(), MODE_FROZEN, MODE_CLAMP, 1'b1, rand_time());
		send_item(3'd7, 5'd9, rand_val(), rand_val(), MODE_MIRROR, MODE_FROZEN, 1'b1,
			rand_time());
		// Paused tick leaves the table alone
		wait_drained();
		write_reg(CFG_PAUSED, 6'd1);
		send_item(OP_TICK, 5'd0, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, 16'hFFFF);
		send_item(OP_READ, 5'd7, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		wait_drained();
		write_reg(CFG_PAUSED, '0);
		send_item(OP_ACTIVE, 5'd31, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, '0);
		send_item(OP_READ, 5'd31, '0, '0, MODE_WRAP, MODE_WRAP, 1'b0, '0);

		// Random phases: sender idle 23%, then 56%, then none
		for (int ph = 0; ph < 6; ph++) begin
			int hold_at;
			idle_pct = (ph < 2) ? 23 : (ph < 4) ? 56 : 0;
			hold_at = $urandom_range(20, 60);
			wait_drained();
			write_reg(CFG_PAUSED, (ph == 3) ? 6'd1 : 6'd0);
			case (ph)
				0: write_reg(CFG_COUNT, FULL_COUNT);
				1: write_reg(CFG_COUNT, COUNT_W'($urandom_range(1, 31)));
				2: write_reg(CFG_COUNT, 6'd63);
				3: write_reg(CFG_COUNT, FULL_COUNT);
				4: write_reg(CFG_COUNT, '0);
				default: write_reg(CFG_COUNT, COUNT_W'($urandom_range(33, 63)));
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == hold_at)
					wait_drained();
				random_item();
			end
		end

		wait_drained();
		repeat (ENTRIES_DEF + 8) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
